@@ rtl/mmcs_pkg.sv @@
package mmcs_pkg;

   // Default sample width
   localparam int SAMPLE_BITS_DEF = 16;

   // Stretched range is 0..255, one quotient bit per divide step
   localparam int QUOT_BITS = 8;
   localparam logic [QUOT_BITS-1:0] FULL_SCALE = 8'hFF;

   // Lane step counter: one prep step plus QUOT_BITS divide steps
   localparam int STEP_BITS = $clog2(QUOT_BITS + 2);

   // Latency from apply accept to lane done
   localparam int LANE_LATENCY = QUOT_BITS + 2;

   // Opcodes
   localparam logic OP_SCAN  = 1'b0;
   localparam logic OP_APPLY = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_HOLD
   } state_type;

   // Control from the sequencer to the merge stage
   typedef struct packed {
      logic scan;
      logic frame_start;
      logic start;
      logic load;
   } mmcs_ctl_type;

endpackage

@@ rtl/min_max_contrast_stretch.sv @@
// Scan word: taken every cycle while idle, no output, extrema updated at the accept edge.
// Apply word: later words stall until the result is loaded into the output register,
// computed by the 8-step restoring quotient loop in each of the three component lanes.
// A stalled output delays the return to idle until the output register frees.
// Reset (synchronous, active high): idle, colour_mode = 0, minimum all ones, maximum zero.
module min_max_contrast_stretch #(
   parameter int SAMPLE_BITS = mmcs_pkg::SAMPLE_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_en,
   input  logic        csr_write_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_opcode,
   input  logic        req_frame_start,
   input  logic [15:0] req_red_in,
   input  logic [15:0] req_green_in,
   input  logic [15:0] req_blue_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_red_out,
   output logic [15:0] rsp_green_out,
   output logic [15:0] rsp_blue_out
);
   import mmcs_pkg::*;

   state_type              state_ff;
   state_type              state_in;
   logic                   colour_mode_ff;
   mmcs_ctl_type           ctl;
   logic                   accept;
   logic                   out_free;
   logic                   red_done;
   logic                   green_done;
   logic                   blue_done;
   logic [SAMPLE_BITS-1:0] red_sample;
   logic [SAMPLE_BITS-1:0] green_sample;
   logic [SAMPLE_BITS-1:0] blue_sample;
   logic [SAMPLE_BITS-1:0] lo;
   logic [SAMPLE_BITS-1:0] hi;
   logic [QUOT_BITS-1:0]   red_quot;
   logic [QUOT_BITS-1:0]   green_quot;
   logic [QUOT_BITS-1:0]   blue_quot;

   // Take samples in their low SAMPLE_BITS bits
   assign red_sample   = SAMPLE_BITS'(req_red_in);
   assign green_sample = SAMPLE_BITS'(req_green_in);
   assign blue_sample  = SAMPLE_BITS'(req_blue_in);

   // Mode register
   always_ff @(posedge clock) begin
      if (reset) begin
         colour_mode_ff <= 1'b0;
      end else if (csr_write_en) begin
         colour_mode_ff <= csr_write_data;
      end
   end

   // Sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_opcode == OP_APPLY)) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (red_done) begin
               state_in = out_free ? ST_IDLE : ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs of the sequencer
   always_comb begin
      req_stall       = (state_ff != ST_IDLE);
      accept          = req_valid && !req_stall;
      ctl.scan        = accept && (req_opcode == OP_SCAN);
      ctl.start       = accept && (req_opcode == OP_APPLY);
      ctl.frame_start = req_frame_start;
      ctl.load        = (((state_ff == ST_RUN) && red_done) || (state_ff == ST_HOLD))
                        && out_free;
   end

   // One lane per color component
   mmcs_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_red (
      .clock  (clock),
      .reset  (reset),
      .start  (ctl.start),
      .sample (red_sample),
      .lo     (lo),
      .hi     (hi),
      .done   (red_done),
      .result (red_quot)
   );

   mmcs_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_green (
      .clock  (clock),
      .reset  (reset),
      .start  (ctl.start),
      .sample (green_sample),
      .lo     (lo),
      .hi     (hi),
      .done   (green_done),
      .result (green_quot)
   );

   mmcs_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_blue (
      .clock  (clock),
      .reset  (reset),
      .start  (ctl.start),
      .sample (blue_sample),
      .lo     (lo),
      .hi     (hi),
      .done   (blue_done),
      .result (blue_quot)
   );

   mmcs_merge #(.SAMPLE_BITS(SAMPLE_BITS)) u_merge (
      .clock         (clock),
      .reset         (reset),
      .ctl           (ctl),
      .colour_mode   (colour_mode_ff),
      .red_sample    (red_sample),
      .green_sample  (green_sample),
      .blue_sample   (blue_sample),
      .red_quot      (red_quot),
      .green_quot    (green_quot),
      .blue_quot     (blue_quot),
      .lo            (lo),
      .hi            (hi),
      .out_free      (out_free),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_red_out   (rsp_red_out),
      .rsp_green_out (rsp_green_out),
      .rsp_blue_out  (rsp_blue_out)
   );

   // Lanes run in lockstep
   a_lanes_lockstep: assert property (@(posedge clock) disable iff (reset)
      (red_done == green_done) && (red_done == blue_done))
      else $error("lanes finished out of step");

   // Lane done follows each apply accept at the lane latency from the package
   a_lane_latency: assert property (@(posedge clock) disable iff (reset)
      ctl.start |-> ##(LANE_LATENCY) red_done)
      else $error("lane did not finish on time");

   // Lanes only finish while the sequencer waits for them
   a_done_in_run: assert property (@(posedge clock) disable iff (reset)
      red_done |-> (state_ff == ST_RUN))
      else $error("lane done outside run state");

endmodule

@@ rtl/mmcs_lane.sv @@
module mmcs_lane #(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic [SAMPLE_BITS-1:0]               sample,
   input  logic [SAMPLE_BITS-1:0]               lo,
   input  logic [SAMPLE_BITS-1:0]               hi,
   output logic                                 done,
   output logic [mmcs_pkg::QUOT_BITS-1:0]       result
);
   import mmcs_pkg::*;

   localparam int REM_BITS = SAMPLE_BITS + QUOT_BITS;
   localparam logic [STEP_BITS-1:0] STEP_PREP = STEP_BITS'(QUOT_BITS + 1);
   localparam logic [STEP_BITS-1:0] STEP_LAST = STEP_BITS'(1);
   localparam logic [STEP_BITS-1:0] STEP_NONE = STEP_BITS'(0);

   logic [STEP_BITS-1:0]   step_ff;
   logic                   done_ff;
   logic                   zero_ff;
   logic                   sat_ff;
   logic [SAMPLE_BITS-1:0] diff_ff;
   logic [SAMPLE_BITS-1:0] span_ff;
   logic [REM_BITS-1:0]    rem_ff;
   logic [REM_BITS-1:0]    dvs_ff;
   logic [QUOT_BITS-1:0]   quot_ff;

   logic                   above;
   logic [SAMPLE_BITS-1:0] diff_in;
   logic [SAMPLE_BITS-1:0] span_in;
   logic                   zero_in;
   logic                   fits;
   logic [REM_BITS-1:0]    rem_sub;
   logic [REM_BITS-1:0]    diff_wide;

   // Clamp the offset from the minimum, flag flat range or sample at or below it
   always_comb begin
      above   = sample > lo;
      diff_in = above ? sample - lo : '0;
      span_in = hi - lo;
      zero_in = !above || (hi <= lo);
   end

   // One restoring step: trial subtract of the shifted divisor
   always_comb begin
      fits      = rem_ff >= dvs_ff;
      rem_sub   = rem_ff - dvs_ff;
      diff_wide = REM_BITS'(diff_ff);
   end

   // Advance the step counter, pulse done after the last quotient bit
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_NONE;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            step_ff <= STEP_PREP;
         end else if (step_ff == STEP_PREP) begin
            step_ff <= STEP_BITS'(QUOT_BITS);
         end else if (step_ff != STEP_NONE) begin
            step_ff <= step_ff - STEP_LAST;
            if (step_ff == STEP_LAST) begin
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Datapath: load offsets, form numerator diff*255, then one bit a step
   always_ff @(posedge clock) begin
      if (start) begin
         diff_ff <= diff_in;
         span_ff <= span_in;
         zero_ff <= zero_in;
      end else if (step_ff == STEP_PREP) begin
         rem_ff  <= (diff_wide << QUOT_BITS) - diff_wide;
         sat_ff  <= diff_ff >= span_ff;
         dvs_ff  <= REM_BITS'(span_ff) << (QUOT_BITS - 1);
         quot_ff <= '0;
      end else if (step_ff != STEP_NONE) begin
         if (fits) begin
            rem_ff <= rem_sub;
         end
         quot_ff <= {quot_ff[QUOT_BITS-2:0], fits};
         dvs_ff  <= dvs_ff >> 1;
      end
   end

   assign done   = done_ff;
   assign result = zero_ff ? '0 : (sat_ff ? FULL_SCALE : quot_ff);

endmodule

@@ rtl/mmcs_merge.sv @@
module mmcs_merge #(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  mmcs_pkg::mmcs_ctl_type            ctl,
   input  logic                              colour_mode,
   input  logic [SAMPLE_BITS-1:0]            red_sample,
   input  logic [SAMPLE_BITS-1:0]            green_sample,
   input  logic [SAMPLE_BITS-1:0]            blue_sample,
   input  logic [mmcs_pkg::QUOT_BITS-1:0]    red_quot,
   input  logic [mmcs_pkg::QUOT_BITS-1:0]    green_quot,
   input  logic [mmcs_pkg::QUOT_BITS-1:0]    blue_quot,
   output logic [SAMPLE_BITS-1:0]            lo,
   output logic [SAMPLE_BITS-1:0]            hi,
   output logic                              out_free,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [7:0]                        rsp_red_out,
   output logic [15:0]                       rsp_green_out,
   output logic [15:0]                       rsp_blue_out
);
   import mmcs_pkg::*;

   logic [SAMPLE_BITS-1:0] lo_ff;
   logic [SAMPLE_BITS-1:0] hi_ff;
   logic [SAMPLE_BITS-1:0] lo_in;
   logic [SAMPLE_BITS-1:0] hi_in;
   logic [15:0]            green_pass_ff;
   logic [15:0]            blue_pass_ff;
   logic                   rsp_valid_ff;
   logic [7:0]             red_out_ff;
   logic [15:0]            green_out_ff;
   logic [15:0]            blue_out_ff;

   logic [SAMPLE_BITS-1:0] base_lo;
   logic [SAMPLE_BITS-1:0] base_hi;
   logic [SAMPLE_BITS-1:0] gb_min;
   logic [SAMPLE_BITS-1:0] gb_max;
   logic [SAMPLE_BITS-1:0] cand_min;
   logic [SAMPLE_BITS-1:0] cand_max;

   // Merge the red sample (all three in colour mode) into the running extrema
   always_comb begin
      base_lo  = ctl.frame_start ? '1 : lo_ff;
      base_hi  = ctl.frame_start ? '0 : hi_ff;
      gb_min   = (green_sample < blue_sample) ? green_sample : blue_sample;
      gb_max   = (green_sample > blue_sample) ? green_sample : blue_sample;
      cand_min = red_sample;
      cand_max = red_sample;
      if (colour_mode) begin
         cand_min = (gb_min < red_sample) ? gb_min : red_sample;
         cand_max = (gb_max > red_sample) ? gb_max : red_sample;
      end
      lo_in = (cand_min < base_lo) ? cand_min : base_lo;
      hi_in = (cand_max > base_hi) ? cand_max : base_hi;
   end

   // Update extrema on a scan word
   always_ff @(posedge clock) begin
      if (reset) begin
         lo_ff <= '1;
         hi_ff <= '0;
      end else if (ctl.scan) begin
         lo_ff <= lo_in;
         hi_ff <= hi_in;
      end
   end

   // Hold grey-mode pass-through components for the word in flight
   always_ff @(posedge clock) begin
      if (ctl.start) begin
         green_pass_ff <= 16'(green_sample);
         blue_pass_ff  <= 16'(blue_sample);
      end
   end

   // Output register: fill on load, drop when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         red_out_ff <= red_quot;
         if (colour_mode) begin
            green_out_ff <= 16'(green_quot);
            blue_out_ff  <= 16'(blue_quot);
         end else begin
            green_out_ff <= green_pass_ff;
            blue_out_ff  <= blue_pass_ff;
         end
      end
   end

   assign lo            = lo_ff;
   assign hi            = hi_ff;
   assign out_free      = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_red_out   = red_out_ff;
   assign rsp_green_out = green_out_ff;
   assign rsp_blue_out  = blue_out_ff;

   // A pending word is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      ctl.load |-> (!rsp_valid_ff || !rsp_stall))
      else $error("output word overwritten while stalled");

   // After any scan the range is never inverted
   a_range_order: assert property (@(posedge clock) disable iff (reset)
      ctl.scan |=> (hi_ff >= lo_ff))
      else $error("maximum below minimum after scan");

   // Extrema move only on scans
   a_extrema_hold: assert property (@(posedge clock) disable iff (reset)
      !ctl.scan |=> ($stable(lo_ff) && $stable(hi_ff)))
      else $error("extrema changed without a scan");

endmodule

@@ test/min_max_contrast_stretch_tb.sv @@
module min_max_contrast_stretch_tb;
   import mmcs_pkg::*;

   localparam int HOLD_CYCLES = 300;
   localparam int IDLE_LIMIT  = 2000;
   localparam int SETTLE_WAIT = LANE_LATENCY + 4;

   typedef struct packed {
      logic [7:0]  red;
      logic [15:0] green;
      logic [15:0] blue;
   } stretched_pixel_type;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_TOGGLE
   } stall_pattern_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_en = 1'b0;
   logic        csr_write_data = 1'b0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_opcode = OP_SCAN;
   logic        req_frame_start = 1'b0;
   logic [15:0] req_red_in = 16'h0000;
   logic [15:0] req_green_in = 16'h0000;
   logic [15:0] req_blue_in = 16'h0000;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_red_out;
   logic [15:0] rsp_green_out;
   logic [15:0] rsp_blue_out;

   // Predictor state: running extrema and the image mode
   logic [15:0] min_level = 16'hFFFF;
   logic [15:0] max_level = 16'h0000;
   logic        colour_on = 1'b0;

   stretched_pixel_type pending_pixels[$];
   int mismatches = 0;
   int burst_left = 0;
   int hold_requests = 0;
   int holds_served = 0;
   int hold_left = 0;
   int mode_left = 0;
   int idle_cycles = 0;
   stall_pattern_type stall_mode = STALL_NONE;

   min_max_contrast_stretch dut (
      .clock           (clock),
      .reset           (reset),
      .csr_write_en    (csr_write_en),
      .csr_write_data  (csr_write_data),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_frame_start (req_frame_start),
      .req_red_in      (req_red_in),
      .req_green_in    (req_green_in),
      .req_blue_in     (req_blue_in),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_red_out     (rsp_red_out),
      .rsp_green_out   (rsp_green_out),
      .rsp_blue_out    (rsp_blue_out)
   );

   always #5 clock = ~clock;

   // Stretch one sample against the current extrema, saturating at full scale
   function automatic logic [7:0] stretch_level(input logic [15:0] v);
      logic [31:0] offset;
      logic [31:0] span;
      logic [31:0] scaled;
      if (max_level <= min_level || v <= min_level) return 8'd0;
      offset = {16'd0, v} - {16'd0, min_level};
      span   = {16'd0, max_level} - {16'd0, min_level};
      scaled = (offset * 32'd255) / span;
      if (scaled > 32'd255) return FULL_SCALE;
      return scaled[7:0];
   endfunction

   task automatic note_level(input logic [15:0] v);
      if (v < min_level) min_level = v;
      if (v > max_level) max_level = v;
   endtask

   // Update extrema on a scan word, queue the stretched pixel on an apply word
   task automatic predict_pixel(input logic op, input logic fs,
                                input logic [15:0] r, input logic [15:0] g,
                                input logic [15:0] b);
      stretched_pixel_type px;
      if (op == OP_SCAN) begin
         if (fs) begin
            min_level = 16'hFFFF;
            max_level = 16'h0000;
         end
         note_level(r);
         if (colour_on) begin
            note_level(g);
            note_level(b);
         end
      end else begin
         px.red = stretch_level(r);
         if (colour_on) begin
            px.green = {8'd0, stretch_level(g)};
            px.blue  = {8'd0, stretch_level(b)};
         end else begin
            px.green = g;
            px.blue  = b;
         end
         pending_pixels.push_back(px);
      end
   endtask

   // Offer one word, idling between bursts, and predict it once accepted
   task automatic send_word(input logic op, input logic fs,
                            input logic [15:0] r, input logic [15:0] g,
                            input logic [15:0] b);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid       <= 1'b1;
      req_opcode      <= op;
      req_frame_start <= fs;
      req_red_in      <= r;
      req_green_in    <= g;
      req_blue_in     <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_pixel(op, fs, r, g, b);
   endtask

   // Drop valid, wait for every pending pixel, then let the lanes go quiet
   task automatic settle_block();
      req_valid <= 1'b0;
      burst_left = 0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);
   endtask

   task automatic set_colour(input logic mode);
      settle_block();
      csr_write_en   <= 1'b1;
      csr_write_data <= mode;
      @(posedge clock);
      csr_write_en <= 1'b0;
      colour_on = mode;
   endtask

   // Mostly near the frame's range, sometimes anywhere or at the rails
   function automatic logic [15:0] pick_level(input logic [15:0] base,
                                              input logic [15:0] spread);
      logic [31:0] raw;
      int roll;
      roll = $urandom_range(0, 19);
      raw = $urandom;
      if (roll == 0) return 16'h0000;
      if (roll == 1) return 16'hFFFF;
      if (roll < 4) return raw[15:0];
      raw = base + $urandom_range(0, spread);
      return raw[15:0];
   endfunction

   task automatic test_grey_directed();
      // empty range right after reset: stretched red is 0, green and blue pass
      send_word(OP_APPLY, 1'b0, 16'h0000, 16'hFFFF, 16'h0000);
      send_word(OP_APPLY, 1'b1, 16'hFFFF, 16'h0000, 16'hFFFF);
      // red spans 1000..3000; green and blue must not count
      send_word(OP_SCAN, 1'b1, 16'd1000, 16'h0000, 16'hFFFF);
      send_word(OP_SCAN, 1'b0, 16'd3000, 16'hFFFF, 16'h0000);
      send_word(OP_APPLY, 1'b0, 16'd1000, 16'h1234, 16'hABCD);
      send_word(OP_APPLY, 1'b0, 16'd3000, 16'h5555, 16'hAAAA);
      send_word(OP_APPLY, 1'b0, 16'd2000, 16'hAAAA, 16'h5555);
      // below the minimum, above the maximum, frame start on apply
      send_word(OP_APPLY, 1'b0, 16'd500, 16'h0001, 16'h8000);
      send_word(OP_APPLY, 1'b0, 16'd60000, 16'h8000, 16'h0001);
      send_word(OP_APPLY, 1'b1, 16'd2500, 16'h7FFF, 16'hFFFE);
      // flat range
      send_word(OP_SCAN, 1'b1, 16'd5000, 16'd9, 16'd60000);
      send_word(OP_APPLY, 1'b0, 16'd5000, 16'h00FF, 16'hFF00);
      send_word(OP_APPLY, 1'b0, 16'd6000, 16'hFF00, 16'h00FF);
   endtask

   task automatic test_colour_directed();
      // full range across the three components
      send_word(OP_SCAN, 1'b1, 16'h0000, 16'hFFFF, 16'h8000);
      send_word(OP_APPLY, 1'b0, 16'h0000, 16'hFFFF, 16'h8000);
      send_word(OP_APPLY, 1'b1, 16'h0001, 16'h7FFF, 16'hFFFE);
      // range 100..400 gathered from all components
      send_word(OP_SCAN, 1'b1, 16'd300, 16'd200, 16'd150);
      send_word(OP_SCAN, 1'b0, 16'd400, 16'd100, 16'd250);
      send_word(OP_APPLY, 1'b0, 16'd100, 16'd400, 16'd250);
      send_word(OP_APPLY, 1'b0, 16'd50, 16'd500, 16'd399);
      // flat range
      send_word(OP_SCAN, 1'b1, 16'd7, 16'd7, 16'd7);
      send_word(OP_APPLY, 1'b0, 16'd7, 16'd8, 16'd6);
   endtask

   // Frames of scans then applies; a few frames are broken on purpose
   task automatic test_random_frames(input int word_budget);
      int sent;
      int scans;
      int applies;
      int k;
      bit broken;
      logic [31:0] raw;
      logic [15:0] base;
      logic [15:0] spread;
      logic op;
      sent = 0;
      while (sent < word_budget) begin
         raw = $urandom;
         base = raw[15:0];
         case ($urandom_range(0, 3))
            0: spread = 16'($urandom_range(0, 15));
            1: spread = 16'($urandom_range(16, 255));
            2: spread = 16'($urandom_range(256, 4095));
            default: spread = raw[31:16];
         endcase
         broken  = ($urandom_range(0, 9) == 0);
         scans   = $urandom_range(1, 6);
         applies = $urandom_range(1, 10);
         for (k = 0; k < scans; k++) begin
            send_word(OP_SCAN, (k == 0) ? !broken : ($urandom_range(0, 15) == 0),
                      pick_level(base, spread), pick_level(base, spread),
                      pick_level(base, spread));
         end
         for (k = 0; k < applies; k++) begin
            op = (broken && $urandom_range(0, 1)) ? OP_SCAN : OP_APPLY;
            send_word(op, 1'($urandom_range(0, 1)), pick_level(base, spread),
                      pick_level(base, spread), pick_level(base, spread));
         end
         sent += scans + applies;
      end
   endtask

   // Hold the result side long enough for the block to back up its input
   task automatic test_output_hold();
      int k;
      logic [31:0] raw;
      hold_requests++;
      burst_left = 64;
      raw = $urandom;
      send_word(OP_SCAN, 1'b1, raw[15:0], raw[31:16], 16'h4000);
      for (k = 0; k < 40; k++) begin
         raw = $urandom;
         send_word((k % 8 == 7) ? OP_SCAN : OP_APPLY, 1'b0, raw[15:0], raw[31:16],
                   raw[23:8]);
      end
      settle_block();
   endtask

   // Result side: hold-off on request, otherwise a changing stall pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         hold_left  <= 0;
         mode_left  <= 50;
         stall_mode <= STALL_NONE;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (holds_served != hold_requests) begin
         holds_served <= holds_served + 1;
         hold_left    <= HOLD_CYCLES - 1;
         rsp_stall    <= 1'b1;
      end else begin
         if (mode_left == 0) begin
            stall_mode <= stall_pattern_type'($urandom_range(0, 3));
            mode_left  <= $urandom_range(20, 200);
         end else begin
            mode_left <= mode_left - 1;
         end
         case (stall_mode)
            STALL_NONE:  rsp_stall <= 1'b0;
            STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
            default:     rsp_stall <= ~rsp_stall;
         endcase
      end
   end

   // Compare each accepted result word with the oldest pending pixel
   always @(posedge clock) begin : check_result
      stretched_pixel_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_pixels.size() == 0) begin
            $display("%0t: unexpected result red %0d green %0d blue %0d", $time,
                     rsp_red_out, rsp_green_out, rsp_blue_out);
            mismatches++;
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_red_out !== want.red) begin
               $display("%0t: red_out expected %0d actual %0d", $time, want.red,
                        rsp_red_out);
               mismatches++;
            end
            if (rsp_green_out !== want.green) begin
               $display("%0t: green_out expected %0d actual %0d", $time, want.green,
                        rsp_green_out);
               mismatches++;
            end
            if (rsp_blue_out !== want.blue) begin
               $display("%0t: blue_out expected %0d actual %0d", $time, want.blue,
                        rsp_blue_out);
               mismatches++;
            end
         end
      end
   end

   // Watchdog: end the run if no word moves for too long
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write_en) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      set_colour(1'b0);
      test_grey_directed();
      set_colour(1'b1);
      test_colour_directed();
      test_random_frames(300);
      set_colour(1'b0);
      test_random_frames(300);
      test_output_hold();
      set_colour(1'b1);
      test_random_frames(150);
      set_colour(1'b0);
      test_random_frames(120);
      settle_block();
      if (mismatches == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
